@@ design/ist_pkg.sv @@
// Shared types and constants for the interval set table.
// Used by ist_ctrl, ist_dp, interval_set_table, ist_checker and tb_top; depends on nothing.
`default_nettype none

package ist_pkg;

    localparam int NUM_W   = 63;
    localparam int ICNT_W  = 7;
    localparam int IN_W    = 192;
    localparam int OUT_W   = 200;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLAIM = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_MERGE,
        S_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    decode;
        logic    claim_init;
        logic    find;
        logic    absorb;
        logic    insert;
        logic    result;
        status_t status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic bad;
        logic nofree;
        logic touch;
        logic absorbed;
        logic full;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ design/ist_ctrl.sv @@
// Controller state machine for the interval set table.
// Depends on ist_pkg; drives the command struct of ist_dp.
`default_nettype none

module ist_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ist_pkg::sts_t sts,
    output ist_pkg::cmd_t      cmd
);

    ist_pkg::state_t  state_reg, state_next;
    ist_pkg::status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ist_pkg::S_IDLE;
            status_reg <= ist_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            ist_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ist_pkg::S_DECODE;
                end
            end
            ist_pkg::S_DECODE:
            begin
                cmd.decode  = 1'b1;
                status_next = ist_pkg::ST_OK;
                unique case (sts.op)
                    ist_pkg::OP_ADD:
                    begin
                        if (sts.bad)
                        begin
                            status_next = ist_pkg::ST_BAD;
                            state_next  = ist_pkg::S_RESULT;
                        end
                        else
                            state_next = ist_pkg::S_FIND;
                    end
                    ist_pkg::OP_CLAIM:
                    begin
                        if (sts.nofree)
                        begin
                            status_next = ist_pkg::ST_BAD;
                            state_next  = ist_pkg::S_RESULT;
                        end
                        else
                        begin
                            cmd.claim_init = 1'b1;
                            state_next     = ist_pkg::S_FIND;
                        end
                    end
                    ist_pkg::OP_PEEK:
                    begin
                        if (sts.nofree)
                            status_next = ist_pkg::ST_BAD;
                        state_next = ist_pkg::S_RESULT;
                    end
                    default:
                        state_next = ist_pkg::S_RESULT;
                endcase
            end
            ist_pkg::S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = ist_pkg::S_MERGE;
            end
            ist_pkg::S_MERGE:
            begin
                if (sts.touch)
                begin
                    cmd.absorb = 1'b1;
                    state_next = ist_pkg::S_FIND;
                end
                else if (!sts.absorbed && sts.full)
                begin
                    status_next = ist_pkg::ST_FULL;
                    state_next  = ist_pkg::S_RESULT;
                end
                else
                begin
                    cmd.insert  = 1'b1;
                    status_next = ist_pkg::ST_OK;
                    state_next  = ist_pkg::S_RESULT;
                end
            end
            ist_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = ist_pkg::S_IDLE;
                end
            end
            default:
                state_next = ist_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ design/ist_dp.sv @@
// Datapath of the interval set table: interval cells, merge arithmetic,
// counters and the output word register. Depends on ist_pkg.
`default_nettype none

module ist_dp #(
    parameter int MAX_INTERVALS = 64,
    parameter int CNT_W         = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ist_pkg::IN_W-1:0]  in_word,
    input  wire ist_pkg::cmd_t             cmd,
    output ist_pkg::sts_t                  sts,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [ist_pkg::OUT_W-1:0]      out_word
);

    localparam int NW = ist_pkg::NUM_W;

    // interval cells, each read at its own place
    logic [NW-1:0] start_mem [MAX_INTERVALS];
    logic [NW-1:0] end_mem   [MAX_INTERVALS];

    logic [CNT_W-1:0] count_reg;
    logic [NW-1:0]    total_reg;
    ist_pkg::op_t     op_reg;
    logic [NW-1:0]    ns_reg, ne_reg, q_reg, old_reg, added_reg, next_reg;
    logic [NW-1:0]    cs_reg, ce_reg;
    logic             member_reg, absorbed_reg, touch_reg;
    logic [CNT_W-1:0] p_reg;
    logic             out_valid_reg;
    logic [ist_pkg::OUT_W-1:0] out_word_reg;

    logic [MAX_INTERVALS-1:0] valid_v, below_v, startle_v, inq_v;
    logic [NW:0]      ne_p1;
    logic [CNT_W-1:0] p_comb;
    logic [NW-1:0]    sel_s, sel_e, next_comb, len_new;
    logic             touch_comb, nofree_comb;

    always_comb
    begin
        ne_p1  = {1'b0, ne_reg} + (NW+1)'(1);
        p_comb = count_reg;
        sel_s  = '0;
        sel_e  = '0;
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            valid_v[i]   = CNT_W'(i) < count_reg;
            below_v[i]   = valid_v[i] &&
                           (({1'b0, end_mem[i]} + (NW+1)'(1)) < {1'b0, ns_reg});
            startle_v[i] = {1'b0, start_mem[i]} <= ne_p1;
            inq_v[i]     = valid_v[i] && (start_mem[i] <= q_reg) && (q_reg <= end_mem[i]);
        end
        // cells are sorted: first non-below cell is the merge/insert point
        for (int i = MAX_INTERVALS - 1; i >= 0; i--)
        begin
            if (valid_v[i] && !below_v[i])
                p_comb = CNT_W'(i);
        end
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            if (CNT_W'(i) == p_comb)
            begin
                sel_s = sel_s | start_mem[i];
                sel_e = sel_e | end_mem[i];
            end
        end
        touch_comb = |(valid_v & ~below_v & startle_v);

        nofree_comb = 1'b0;
        if (count_reg == '0 || start_mem[0] != NW'(1))
            next_comb = NW'(1);
        else if (&end_mem[0])
        begin
            next_comb   = '0;
            nofree_comb = 1'b1;
        end
        else
            next_comb = end_mem[0] + NW'(1);

        len_new = ne_reg - ns_reg + NW'(1) - old_reg;
    end

    always_comb
    begin
        sts.op       = op_reg;
        sts.bad      = (ns_reg == '0) || (ns_reg > ne_reg);
        sts.nofree   = nofree_comb;
        sts.touch    = touch_reg;
        sts.absorbed = absorbed_reg;
        sts.full     = count_reg == CNT_W'(MAX_INTERVALS);
        sts.out_free = !out_valid_reg || out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.absorb)
                count_reg <= count_reg - CNT_W'(1);
            else if (cmd.insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
                total_reg <= total_reg + len_new;
            end
            if (cmd.result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= ist_pkg::op_t'(in_word[1:0]);
            ns_reg       <= in_word[NW+1:2];
            ne_reg       <= in_word[2*NW+1:NW+2];
            q_reg        <= in_word[3*NW+1:2*NW+2];
            old_reg      <= '0;
            added_reg    <= '0;
            absorbed_reg <= 1'b0;
        end
        if (cmd.decode)
        begin
            member_reg <= (op_reg == ist_pkg::OP_QUERY) && (|inq_v);
            next_reg   <= (op_reg == ist_pkg::OP_PEEK || op_reg == ist_pkg::OP_CLAIM)
                          ? next_comb : '0;
        end
        if (cmd.claim_init)
        begin
            ns_reg <= next_comb;
            ne_reg <= next_comb;
        end
        if (cmd.find)
        begin
            p_reg     <= p_comb;
            touch_reg <= touch_comb;
            cs_reg    <= sel_s;
            ce_reg    <= sel_e;
        end
        if (cmd.absorb)
        begin
            ns_reg       <= (cs_reg < ns_reg) ? cs_reg : ns_reg;
            ne_reg       <= (ce_reg > ne_reg) ? ce_reg : ne_reg;
            old_reg      <= old_reg + (ce_reg - cs_reg + NW'(1));
            absorbed_reg <= 1'b1;
        end
        if (cmd.insert)
            added_reg <= len_new;
        if (cmd.result)
            out_word_reg <= {1'b0, ist_pkg::ICNT_W'(count_reg), total_reg, cmd.status,
                             next_reg, member_reg, added_reg};
    end

    // cells: remove at p (shift down) or insert at p (shift up)
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            if (cmd.absorb && CNT_W'(i) >= p_reg)
            begin
                start_mem[i] <= start_mem[(i < MAX_INTERVALS - 1) ? i + 1 : i];
                end_mem[i]   <= end_mem[(i < MAX_INTERVALS - 1) ? i + 1 : i];
            end
            else if (cmd.insert && CNT_W'(i) > p_reg)
            begin
                start_mem[i] <= start_mem[(i > 0) ? i - 1 : i];
                end_mem[i]   <= end_mem[(i > 0) ? i - 1 : i];
            end
            else if (cmd.insert && CNT_W'(i) == p_reg)
            begin
                start_mem[i] <= ns_reg;
                end_mem[i]   <= ne_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

@@ design/interval_set_table.sv @@
// Top level of the interval set table: stream ports, controller and datapath.
// Depends on ist_pkg, ist_ctrl and ist_dp.
//
// Keeps a sorted set of up to MAX_INTERVALS disjoint, non-adjacent intervals
// of positive 63-bit numbers. Each input word is one operation: add a range,
// membership query, next-free peek, or next-free claim; each gives exactly
// one output word. Adds absorb every stored interval they overlap or touch.
// Items are taken one at a time. A query, a peek, a bad range or a missing
// free number passes from accept through the decode and result states; an
// add or claim, including one dropped because the table is full, also passes
// through the find and merge states, and again for each stored interval it
// absorbs, since each absorbed interval costs one search over the cells and
// one compaction of the cell array. The output register lets the next word be
// accepted while a result waits. Status is 0 ok, 1 table full (word dropped),
// 2 bad range or no free number (word dropped). Stored intervals past the
// count are never read, so there is no clearing pass after reset.
`default_nettype none

module interval_set_table #(
    parameter int MAX_INTERVALS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation[1:0], range_start[64:2], range_end[127:65],
    // query_number[190:128], zero[191]
    input  wire logic [ist_pkg::IN_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // added_count[62:0], member_flag[63], next_number[126:64], status[128:127],
    // total_count[191:129], interval_count[198:192], zero[199]
    output logic [ist_pkg::OUT_W-1:0]     m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    ist_pkg::cmd_t cmd;
    ist_pkg::sts_t sts;

    ist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ist_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .CNT_W         (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ dv/ist_checker.sv @@
// Scoreboard for the interval set table: watches both stream channels, keeps a
// shadow copy of the interval set, and compares every output word in order.
// Depends on ist_pkg.
`default_nettype none

module ist_checker #(
    parameter int MAX_INTERVALS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic [ist_pkg::IN_W-1:0] s_data,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic [ist_pkg::OUT_W-1:0] m_data,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ist_pkg::*;

    localparam logic [62:0] NUM_MAX = {63{1'b1}};

    typedef struct {
        logic [62:0] added;
        logic        member;
        logic [62:0] next_num;
        status_t     status;
        logic [62:0] total;
        logic [6:0]  icount;
    } ist_result_t;

    // shadow interval set; 64-bit so that end+1 never wraps
    logic [63:0] shadow_lo [MAX_INTERVALS];
    logic [63:0] shadow_hi [MAX_INTERVALS];
    int          shadow_n;
    logic [62:0] shadow_total;

    ist_result_t awaited_results [$];

    // add [s, e]; merges every interval that overlaps or touches it
    function automatic status_t merge_range(input logic [63:0] s, input logic [63:0] e,
                                            output logic [63:0] gain);
        int lo;
        int hi;
        int gone;
        logic [63:0] ns;
        logic [63:0] ne;
        logic [63:0] old;
        lo   = 0;
        hi   = 0;
        old  = 0;
        gain = 0;
        while (lo < shadow_n && shadow_hi[lo] + 64'd1 < s)
            lo++;
        while (hi < shadow_n && shadow_lo[hi] <= e + 64'd1)
            hi++;
        if (lo >= hi) begin
            if (shadow_n >= MAX_INTERVALS)
                return ST_FULL;
            for (int i = shadow_n; i > lo; i--) begin
                shadow_lo[i] = shadow_lo[i-1];
                shadow_hi[i] = shadow_hi[i-1];
            end
            shadow_lo[lo] = s;
            shadow_hi[lo] = e;
            shadow_n++;
            gain = e - s + 64'd1;
        end
        else begin
            ns   = (shadow_lo[lo] < s) ? shadow_lo[lo] : s;
            ne   = (shadow_hi[hi-1] > e) ? shadow_hi[hi-1] : e;
            gone = hi - lo - 1;
            for (int i = lo; i < hi; i++)
                old += shadow_hi[i] - shadow_lo[i] + 64'd1;
            shadow_lo[lo] = ns;
            shadow_hi[lo] = ne;
            for (int i = lo + 1; i + gone < shadow_n; i++) begin
                shadow_lo[i] = shadow_lo[i+gone];
                shadow_hi[i] = shadow_hi[i+gone];
            end
            shadow_n -= gone;
            gain = (ne - ns + 64'd1) - old;
        end
        shadow_total = shadow_total + gain[62:0];
        return ST_OK;
    endfunction

    function automatic ist_result_t predict_word(input logic [IN_W-1:0] w);
        ist_result_t r;
        op_t         op;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] q;
        logic [63:0] gain;
        logic [63:0] nxt;
        op   = op_t'(w[1:0]);
        s    = {1'b0, w[64:2]};
        e    = {1'b0, w[127:65]};
        q    = {1'b0, w[190:128]};
        gain = 0;
        nxt  = 0;
        r.member = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (s < 64'd1 || s > e)
                    r.status = ST_BAD;
                else
                    r.status = merge_range(s, e, gain);
            end
            OP_QUERY: begin
                for (int i = 0; i < shadow_n; i++)
                    if (shadow_lo[i] <= q && q <= shadow_hi[i])
                        r.member = 1'b1;
            end
            default: begin
                if (shadow_n == 0 || shadow_lo[0] != 64'd1)
                    nxt = 64'd1;
                else if (shadow_hi[0] >= {1'b0, NUM_MAX})
                    nxt = 64'd0;    // whole number space taken
                else
                    nxt = shadow_hi[0] + 64'd1;
                if (nxt == 64'd0)
                    r.status = ST_BAD;
                else if (op == OP_CLAIM)
                    r.status = merge_range(nxt, nxt, gain);
            end
        endcase
        r.added    = gain[62:0];
        r.next_num = nxt[62:0];
        r.total    = shadow_total;
        r.icount   = 7'(shadow_n);
        return r;
    endfunction

    assign pending = awaited_results.size();

    always @(posedge clk or negedge rst_n) begin
        ist_result_t exp_r;
        int          nerr;
        nerr = 0;
        if (!rst_n) begin
            shadow_n     <= 0;
            shadow_total <= '0;
            errors       <= 0;
            awaited_results.delete();
        end
        else begin
            if (s_valid && s_ready)
                awaited_results.push_back(predict_word(s_data));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("output word with no result awaited");
                    nerr++;
                end
                else begin
                    exp_r = awaited_results.pop_front();
                    if (m_data[62:0] !== exp_r.added) begin
                        $error("added_count exp %0d act %0d", exp_r.added, m_data[62:0]);
                        nerr++;
                    end
                    if (m_data[63] !== exp_r.member) begin
                        $error("member_flag exp %0d act %0d", exp_r.member, m_data[63]);
                        nerr++;
                    end
                    if (m_data[126:64] !== exp_r.next_num) begin
                        $error("next_number exp %0d act %0d", exp_r.next_num,
                               m_data[126:64]);
                        nerr++;
                    end
                    if (m_data[128:127] !== exp_r.status) begin
                        $error("status exp %0d act %0d", exp_r.status, m_data[128:127]);
                        nerr++;
                    end
                    if (m_data[191:129] !== exp_r.total) begin
                        $error("total_count exp %0d act %0d", exp_r.total,
                               m_data[191:129]);
                        nerr++;
                    end
                    if (m_data[198:192] !== exp_r.icount) begin
                        $error("interval_count exp %0d act %0d", exp_r.icount,
                               m_data[198:192]);
                        nerr++;
                    end
                end
            end
            errors <= errors + nerr;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Stimulus and verdict for the interval set table.
// Depends on ist_pkg, interval_set_table and ist_checker.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ist_pkg::*;

    localparam logic [62:0] NUM_MAX     = {63{1'b1}};
    localparam int          PHASES      = 19;
    localparam int          CYCLE_LIMIT = 2000000;
    // receiver hold-off window and the stretch with no idling on either side
    localparam int          HOLD_FROM   = 3000;
    localparam int          HOLD_TO     = 3600;
    localparam int          CALM_FROM   = 8000;
    localparam int          CALM_TO     = 11000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;   // operation, range_start, range_end, query_number
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;   // added_count, member_flag, next_number, status,
                                        // total_count, interval_count
    int                 cycle_cnt = 0;
    int                 rx_cycles = 0;
    int                 errors;
    int                 pending;

    interval_set_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    ist_checker chk (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_data (s_axis_tdata),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_data (m_axis_tdata),
        .errors (errors),
        .pending(pending)
    );

    always #5 clk = ~clk;

    // run guard
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off so the block backs up,
    // and a calm stretch with no stalls
    always @(posedge clk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_TO)
            m_axis_tready <= 1'b0;
        else if (rx_cycles >= CALM_FROM && rx_cycles < CALM_TO)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 20);
    end

    function automatic logic [62:0] rand_num();
        return 63'({$urandom, $urandom});
    endfunction

    // one word, then a random gap outside the calm stretch
    task automatic send_word(input op_t op, input logic [62:0] s, input logic [62:0] e,
                             input logic [62:0] q);
        s_axis_tdata  <= {1'b0, q, e, s, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!(cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO)) begin
            while ($urandom_range(99) < 20) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        logic [62:0] base;
        logic [62:0] s;
        logic [62:0] len;
        int          pick;
        int          burst;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty set, bad ranges, merges, top of the number space
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_PEEK, 0, 0, 0);
        send_word(OP_CLAIM, 0, 0, 0);               // takes 1
        send_word(OP_ADD, 0, 5, 0);                 // start below 1
        send_word(OP_ADD, 9, 8, 0);                 // start past end
        send_word(OP_ADD, NUM_MAX, 0, 0);
        send_word(OP_ADD, 5, 5, 0);
        send_word(OP_ADD, 7, 9, 0);
        send_word(OP_ADD, 6, 6, 0);                 // bridges two intervals
        send_word(OP_ADD, 3, 12, 0);                // overlap
        send_word(OP_ADD, 2, 2, 0);                 // touch from below, joins 1
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, 1);
        send_word(OP_QUERY, 0, 0, 12);
        send_word(OP_QUERY, 0, 0, 13);
        send_word(OP_PEEK, 0, 0, 0);
        send_word(OP_CLAIM, 0, 0, 0);
        send_word(OP_ADD, NUM_MAX, NUM_MAX, 0);
        send_word(OP_ADD, NUM_MAX - 5, NUM_MAX - 1, 0);
        send_word(OP_QUERY, 0, 0, NUM_MAX);
        send_word(OP_QUERY, 0, 0, NUM_MAX - 6);
        send_word(OP_ADD, 1, NUM_MAX - 100, 0);     // absorbs almost everything

        // random phases, each in a window of its own above the last; the
        // opening add of a phase folds all earlier windows into one interval
        for (int p = 0; p < PHASES; p++) begin
            if (p == 5)
                drain_results();
            base = (p == PHASES - 1) ? NUM_MAX - 3000 : (63'(p + 1) << 58) + 63'($urandom);
            send_word(OP_ADD, 1, base - 1, 0);
            // every other phase packs in enough singletons to fill the table
            burst = (p % 2 == 1) ? 70 : 0;
            for (int i = 0; i < burst; i++)
                send_word(OP_ADD, base + 63'(3 * i + 2), base + 63'(3 * i + 2), 0);
            for (int i = 0; i < 100 - burst; i++) begin
                pick = $urandom_range(99);
                s    = base + 63'($urandom_range(400));
                len  = 63'($urandom_range(6));
                if (pick < 8)
                    send_word(op_t'($urandom_range(3)), rand_num(), rand_num(), rand_num());
                else if (pick < 11)
                    send_word(OP_ADD, s + len + 1, s, 0);
                else if (pick < 53)
                    send_word(OP_ADD, s, s + len, 0);
                else if (pick < 60)
                    send_word(OP_ADD, s, s + 63'($urandom_range(200)), 0);
                else if (pick < 80)
                    send_word(OP_QUERY, rand_num(), rand_num(),
                              ($urandom_range(9) == 0) ? rand_num() : s);
                else if (pick < 88)
                    send_word(OP_PEEK, rand_num(), rand_num(), rand_num());
                else
                    send_word(OP_CLAIM, rand_num(), rand_num(), rand_num());
            end
        end

        // whole number space taken: no free number left
        send_word(OP_ADD, 1, NUM_MAX, 0);
        send_word(OP_PEEK, 0, 0, 0);
        send_word(OP_CLAIM, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, NUM_MAX);
        send_word(OP_QUERY, 0, 0, 0);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
